// ----- hdl/sgfa_pkg.sv -----
`default_nettype none
package sgfa_pkg;

   localparam int POS_W   = 24;
   localparam int MASS_W  = 32;
   localparam int GAIN_W  = 32;
   localparam int FORCE_W = 48;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 32'd1;
   // softening length of 3 in q.8
   localparam logic [24:0] SOFTEN_Q8 = 25'd768;

   localparam logic [5:0] SQRT_STEPS = 6'd25;
   localparam logic [5:0] DIV_STEPS  = 6'd52;

   localparam logic [48:0]        TERM_CAP = 49'h1_0000_0000_0000;
   localparam logic signed [47:0] ACC_MAX  = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] ACC_MIN  = -48'sh8000_0000_0000;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_SQX,
      OP_SQY,
      OP_GM,
      OP_SQRT_INIT,
      OP_SQRT_STEP,
      OP_RSET,
      OP_R2,
      OP_R3L,
      OP_R3H,
      OP_R3S,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_TXL,
      OP_TXH,
      OP_TYL,
      OP_TYH,
      OP_TYS,
      OP_ACC,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

// ----- hdl/sgfa_ctrl.sv -----
`default_nettype none
module sgfa_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  sgfa_pkg::status_type    status,
   output sgfa_pkg::cmd_type       cmd
);
   import sgfa_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_SQX, S_SQY, S_GM, S_SQRT_INIT, S_SQRT, S_RSET, S_R2, S_R3L, S_R3H,
      S_R3S, S_DIV_INIT, S_DIV, S_TXL, S_TXH, S_TYL, S_TYH, S_TYS, S_ACC, S_OUT
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_SQX;
            end
         end
         S_SQX: begin cmd.op = OP_SQX; state_in = S_SQY; end
         S_SQY: begin cmd.op = OP_SQY; state_in = S_GM; end
         S_GM:  begin cmd.op = OP_GM;  state_in = S_SQRT_INIT; end
         S_SQRT_INIT: begin
            cmd.op   = OP_SQRT_INIT;
            cnt_in   = SQRT_STEPS - 6'd1;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.op = OP_SQRT_STEP;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) state_in = S_RSET;
         end
         S_RSET: begin cmd.op = OP_RSET; state_in = S_R2; end
         S_R2:   begin cmd.op = OP_R2;   state_in = S_R3L; end
         S_R3L:  begin cmd.op = OP_R3L;  state_in = S_R3H; end
         S_R3H:  begin cmd.op = OP_R3H;  state_in = S_R3S; end
         S_R3S:  begin cmd.op = OP_R3S;  state_in = S_DIV_INIT; end
         S_DIV_INIT: begin
            cmd.op   = OP_DIV_INIT;
            cnt_in   = DIV_STEPS - 6'd1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = OP_DIV_STEP;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) state_in = S_TXL;
         end
         S_TXL: begin cmd.op = OP_TXL; state_in = S_TXH; end
         S_TXH: begin cmd.op = OP_TXH; state_in = S_TYL; end
         S_TYL: begin cmd.op = OP_TYL; state_in = S_TYH; end
         S_TYH: begin cmd.op = OP_TYH; state_in = S_TYS; end
         S_TYS: begin cmd.op = OP_TYS; state_in = S_ACC; end
         S_ACC: begin cmd.op = OP_ACC; state_in = S_OUT; end
         S_OUT: begin
            // wait for the output register to be free
            if (status.out_free) begin
               cmd.op   = OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= 6'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/sgfa_dpath.sv -----
`default_nettype none
module sgfa_dpath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  sgfa_pkg::cmd_type                  cmd,
   output sgfa_pkg::status_type               status,
   input  wire logic [sgfa_pkg::POS_W-1:0]    source_x,
   input  wire logic [sgfa_pkg::POS_W-1:0]    source_y,
   input  wire logic [sgfa_pkg::MASS_W-1:0]   source_mass,
   input  wire logic [sgfa_pkg::POS_W-1:0]    target_x,
   input  wire logic [sgfa_pkg::POS_W-1:0]    target_y,
   input  wire logic                          start_new_target,
   input  wire logic                          gain_we,
   input  wire logic [sgfa_pkg::GAIN_W-1:0]   gain_wdata,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [sgfa_pkg::FORCE_W-1:0] force_x,
   output logic signed [sgfa_pkg::FORCE_W-1:0] force_y,
   output logic                               saturated
);
   import sgfa_pkg::*;

   function automatic logic [48:0] acc_step(input logic signed [47:0] base,
                                            input logic [75:0] prod, input logic neg);
      logic [48:0]        mag;
      logic signed [49:0] term;
      logic signed [50:0] sum;
      logic [48:0]        res;
      mag  = (prod[75:48] != 28'd0) ? TERM_CAP : prod[48:0];
      term = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      sum  = 51'(base) + 51'(term);
      if (sum > 51'(ACC_MAX))      res = {1'b1, ACC_MAX};
      else if (sum < 51'(ACC_MIN)) res = {1'b1, ACC_MIN};
      else                         res = {1'b0, sum[47:0]};
      return res;
   endfunction

   logic [GAIN_W-1:0] gain_ff;
   logic [23:0] adx_ff, ady_ff;
   logic        negx_ff, negy_ff, start_ff;
   logic [31:0] mass_ff;
   logic [63:0] mul_ff, p_ff;
   logic [49:0] s_ff;
   logic [25:0] srem_ff;
   logic [24:0] root_ff, r_ff, r2hi_ff;
   logic [74:0] r3_ff, drem_ff;
   logic [51:0] qn_ff;
   logic [75:0] tx_ff, ty_ff;
   logic signed [47:0] acc_x_ff, acc_y_ff;
   logic        sat_ff;
   logic        out_valid_ff;
   logic signed [47:0] out_x_ff, out_y_ff;
   logic        out_sat_ff;

   logic [24:0] dx, dy;
   logic [31:0] mul_a, mul_b;
   logic        mul_en;
   logic [27:0] sq_cur, sq_trial;
   logic        sq_ge;
   logic [75:0] dv_cur, dv_diff;
   logic        dv_ge;
   logic signed [47:0] base_x, base_y;
   logic [48:0] res_x, res_y;

   assign dx = {1'b0, source_x} - {1'b0, target_x};
   assign dy = {1'b0, source_y} - {1'b0, target_y};

   // one shared 32x32 multiplier, product registered
   always_comb begin
      mul_a  = 32'd0;
      mul_b  = 32'd0;
      mul_en = 1'b1;
      case (cmd.op)
         OP_SQX: begin mul_a = {8'd0, adx_ff}; mul_b = {8'd0, adx_ff}; end
         OP_SQY: begin mul_a = {8'd0, ady_ff}; mul_b = {8'd0, ady_ff}; end
         OP_GM:  begin mul_a = gain_ff; mul_b = mass_ff; end
         OP_R2:  begin mul_a = {7'd0, r_ff}; mul_b = {7'd0, r_ff}; end
         OP_R3L: begin mul_a = {7'd0, mul_ff[24:0]}; mul_b = {7'd0, r_ff}; end
         OP_R3H: begin mul_a = {7'd0, r2hi_ff}; mul_b = {7'd0, r_ff}; end
         OP_TXL: begin mul_a = {6'd0, qn_ff[25:0]}; mul_b = {8'd0, adx_ff}; end
         OP_TXH: begin mul_a = {6'd0, qn_ff[51:26]}; mul_b = {8'd0, adx_ff}; end
         OP_TYL: begin mul_a = {6'd0, qn_ff[25:0]}; mul_b = {8'd0, ady_ff}; end
         OP_TYH: begin mul_a = {6'd0, qn_ff[51:26]}; mul_b = {8'd0, ady_ff}; end
         default: mul_en = 1'b0;
      endcase
   end

   // one root digit per step
   assign sq_cur   = {srem_ff, s_ff[49:48]};
   assign sq_trial = {1'b0, root_ff, 2'b01};
   assign sq_ge    = (sq_cur >= sq_trial);

   // one quotient bit per step
   assign dv_cur  = {drem_ff, qn_ff[51]};
   assign dv_diff = dv_cur - {1'b0, r3_ff};
   assign dv_ge   = (dv_cur >= {1'b0, r3_ff});

   assign base_x = start_ff ? 48'sd0 : acc_x_ff;
   assign base_y = start_ff ? 48'sd0 : acc_y_ff;
   assign res_x  = acc_step(base_x, tx_ff, negx_ff);
   assign res_y  = acc_step(base_y, ty_ff, negy_ff);

   assign status.out_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (mul_en) mul_ff <= mul_a * mul_b;
      case (cmd.op)
         OP_LOAD: begin
            negx_ff  <= dx[24];
            negy_ff  <= dy[24];
            adx_ff   <= dx[24] ? 24'(-dx) : dx[23:0];
            ady_ff   <= dy[24] ? 24'(-dy) : dy[23:0];
            mass_ff  <= source_mass;
            start_ff <= start_new_target;
         end
         OP_SQY: s_ff <= {2'd0, mul_ff[47:0]};
         OP_GM:  s_ff <= s_ff + {2'd0, mul_ff[47:0]};
         OP_SQRT_INIT: begin
            p_ff    <= mul_ff;
            srem_ff <= 26'd0;
            root_ff <= 25'd0;
         end
         OP_SQRT_STEP: begin
            s_ff    <= {s_ff[47:0], 2'b00};
            srem_ff <= sq_ge ? 26'(sq_cur - sq_trial) : sq_cur[25:0];
            root_ff <= {root_ff[23:0], sq_ge};
         end
         OP_RSET: r_ff    <= root_ff + SOFTEN_Q8;
         OP_R3L:  r2hi_ff <= mul_ff[49:25];
         OP_R3H:  r3_ff   <= {25'd0, mul_ff[49:0]};
         OP_R3S:  r3_ff   <= r3_ff + {mul_ff[49:0], 25'd0};
         OP_DIV_INIT: begin
            // dividend is p << 16; its top 28 bits are always below r^3
            drem_ff <= {47'd0, p_ff[63:36]};
            qn_ff   <= {p_ff[35:0], 16'd0};
         end
         OP_DIV_STEP: begin
            drem_ff <= dv_ge ? dv_diff[74:0] : dv_cur[74:0];
            qn_ff   <= {qn_ff[50:0], dv_ge};
         end
         OP_TXH: tx_ff <= {26'd0, mul_ff[49:0]};
         OP_TYL: tx_ff <= tx_ff + {mul_ff[49:0], 26'd0};
         OP_TYH: ty_ff <= {26'd0, mul_ff[49:0]};
         OP_TYS: ty_ff <= ty_ff + {mul_ff[49:0], 26'd0};
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= GAIN_RESET;
         acc_x_ff     <= 48'sd0;
         acc_y_ff     <= 48'sd0;
         sat_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (gain_we) gain_ff <= gain_wdata;
         if (cmd.op == OP_ACC) begin
            acc_x_ff <= res_x[47:0];
            acc_y_ff <= res_y[47:0];
            sat_ff   <= res_x[48] | res_y[48];
         end
         if (cmd.op == OP_EMIT) out_valid_ff <= 1'b1;
         else if (rsp_ready)    out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_EMIT) begin
         out_x_ff   <= acc_x_ff;
         out_y_ff   <= acc_y_ff;
         out_sat_ff <= sat_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign force_x   = out_x_ff;
   assign force_y   = out_y_ff;
   assign saturated = out_sat_ff;

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_EMIT |-> status.out_free)
      else $error("word emitted over an unread result");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_EMIT |=> rsp_valid)
      else $error("emitted word not presented");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_DIV_STEP |-> drem_ff < r3_ff)
      else $error("division remainder not below divisor");

endmodule
`default_nettype wire

// ----- hdl/softened_gravity_force_accumulator.sv -----
// softened gravity force accumulator
// req_ channel: one word per source/target pair (positions q16.8, mass).
// start_new_target clears both force accumulators before the pair is added.
// rsp_ channel: the updated accumulated force per axis (q24.24) and a flag
// set when either accumulator clipped on this word.
// csr_ channel: writes the q8.24 gain; csr_ready is always high. write it
// only while no word is in flight.
// a word is taken only while idle, after the previous one has reached the
// output register. each word runs the 25-step bit-serial square root and
// the 52-step restoring divide by r^3, with ten passes through the shared
// 32x32 multiplier.
// a finished result waits in the output register; the next word is
// accepted meanwhile, and only the final hand-over stalls while rsp_ready
// is low.
// reset: accumulators cleared, gain set to one lsb, no result pending.
`default_nettype none
module softened_gravity_force_accumulator (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [sgfa_pkg::POS_W-1:0]      req_source_x,
   input  wire logic [sgfa_pkg::POS_W-1:0]      req_source_y,
   input  wire logic [sgfa_pkg::MASS_W-1:0]     req_source_mass,
   input  wire logic [sgfa_pkg::POS_W-1:0]      req_target_x,
   input  wire logic [sgfa_pkg::POS_W-1:0]      req_target_y,
   input  wire logic                            req_start_new_target,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [sgfa_pkg::GAIN_W-1:0]     csr_gravity_gain,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic signed [sgfa_pkg::FORCE_W-1:0]  rsp_force_x,
   output logic signed [sgfa_pkg::FORCE_W-1:0]  rsp_force_y,
   output logic                                 rsp_saturated
);
   import sgfa_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   sgfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sgfa_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .source_x         (req_source_x),
      .source_y         (req_source_y),
      .source_mass      (req_source_mass),
      .target_x         (req_target_x),
      .target_y         (req_target_y),
      .start_new_target (req_start_new_target),
      .gain_we          (csr_valid & csr_ready),
      .gain_wdata       (csr_gravity_gain),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .force_x          (rsp_force_x),
      .force_y          (rsp_force_y),
      .saturated        (rsp_saturated)
   );

endmodule
`default_nettype wire
